// ===== hw/rtl/hashed_address_set_insert_assert.svh =====
// Assertion macros shared by the hashed address set modules.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef HASHED_ADDRESS_SET_INSERT_ASSERT_SVH
`define HASHED_ADDRESS_SET_INSERT_ASSERT_SVH

// Same-cycle implication
`define HASI_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define HASI_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/hasi_pkg.sv =====
`timescale 1ns / 1ps

package hasi_pkg;

    // Table geometry
    localparam int CAPACITY = 1024;
    localparam int SLOT_W   = $clog2(CAPACITY);

    // Field widths
    localparam int KEY_W    = 32;
    localparam int CNT_W    = 10;
    localparam int STATUS_W = 2;
    localparam int CFG_W    = 32;
    localparam int PADDR_W  = 3;

    // Width for the limit compare, wide enough for count + 1 and CAPACITY - 1
    localparam int CMP_W = ((SLOT_W > CNT_W) ? SLOT_W : CNT_W) + 1;

    // RAM word: occupied flag over the key
    localparam int RAM_W = KEY_W + 1;

    // Reset value of the entry limit
    localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = CNT_W'(716);

    // Mixer constants
    localparam logic [31:0] HASH_MUL1 = 32'h7feb352d;
    localparam logic [31:0] HASH_MUL2 = 32'h846ca68b;
    localparam int HASH_SH_A = 16;
    localparam int HASH_SH_B = 15;

    // Result codes
    localparam logic [STATUS_W-1:0] STATUS_INSERTED = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_PRESENT  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd2;

    // Register index of the entry limit
    localparam logic REG_MAX_ENTRIES = 1'b0;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_HASH1,
        ST_HASH2,
        ST_ADDR,
        ST_PROBE
    } state_t;

    // Controller to datapath
    typedef struct packed {
        logic                load_key;
        logic                hash1;
        logic                hash2;
        logic                rd_home;
        logic                rd_next;
        logic                wr_clear;
        logic                wr_insert;
        logic                res_strobe;
        logic [STATUS_W-1:0] res_status;
    } ctrl_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic full;
        logic rd_occ;
        logic rd_match;
        logic clr_last;
    } dp_stat_t;

endpackage

// ===== hw/rtl/hasi_ram.sv =====
`timescale 1ns / 1ps

module hasi_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // One write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/hasi_ctrl.sv =====
`timescale 1ns / 1ps
`include "hashed_address_set_insert_assert.svh"

module hasi_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  hasi_pkg::dp_stat_t stat,
    output hasi_pkg::ctrl_cmd_t cmd
);

    hasi_pkg::state_t state_reg;
    hasi_pkg::state_t state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= hasi_pkg::ST_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        busy       = 1'b1;
        case (state_reg)
            hasi_pkg::ST_CLEAR:
            begin
                // sweep the table, one slot a cycle
                cmd.wr_clear = 1'b1;
                if (stat.clr_last)
                begin
                    state_next = hasi_pkg::ST_IDLE;
                end
            end
            hasi_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    cmd.load_key = 1'b1;
                    if (stat.full)
                    begin
                        // limit reached: refuse without touching the table
                        cmd.res_strobe = 1'b1;
                        cmd.res_status = hasi_pkg::STATUS_FULL;
                    end
                    else
                    begin
                        state_next = hasi_pkg::ST_HASH1;
                    end
                end
            end
            hasi_pkg::ST_HASH1:
            begin
                cmd.hash1  = 1'b1;
                state_next = hasi_pkg::ST_HASH2;
            end
            hasi_pkg::ST_HASH2:
            begin
                cmd.hash2  = 1'b1;
                state_next = hasi_pkg::ST_ADDR;
            end
            hasi_pkg::ST_ADDR:
            begin
                cmd.rd_home = 1'b1;
                state_next  = hasi_pkg::ST_PROBE;
            end
            hasi_pkg::ST_PROBE:
            begin
                if (!stat.rd_occ)
                begin
                    cmd.wr_insert  = 1'b1;
                    cmd.res_strobe = 1'b1;
                    cmd.res_status = hasi_pkg::STATUS_INSERTED;
                    state_next     = hasi_pkg::ST_IDLE;
                end
                else if (stat.rd_match)
                begin
                    cmd.res_strobe = 1'b1;
                    cmd.res_status = hasi_pkg::STATUS_PRESENT;
                    state_next     = hasi_pkg::ST_IDLE;
                end
                else
                begin
                    // occupied by another key: step to the next slot
                    cmd.rd_next = 1'b1;
                end
            end
            default:
            begin
                state_next = hasi_pkg::ST_IDLE;
            end
        endcase
    end

    // Checks
    `HASI_ASSERT_NXT(a_probe_continues,
        state_reg == hasi_pkg::ST_PROBE && stat.rd_occ && !stat.rd_match,
        state_reg == hasi_pkg::ST_PROBE, "probe left on a foreign key")
    `HASI_ASSERT_NXT(a_accept_hashes,
        start && !busy && !stat.full,
        state_reg == hasi_pkg::ST_HASH1, "accepted add did not start hashing")
    `HASI_ASSERT_NXT(a_result_idles,
        cmd.res_strobe, state_reg == hasi_pkg::ST_IDLE, "not idle after result")
    `HASI_ASSERT_IMP(a_insert_not_clear,
        cmd.wr_insert, !cmd.wr_clear && state_reg == hasi_pkg::ST_PROBE,
        "insert write outside probe")

endmodule

// ===== hw/rtl/hasi_dp.sv =====
`timescale 1ns / 1ps

module hasi_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  hasi_pkg::ctrl_cmd_t               cmd,
    output hasi_pkg::dp_stat_t                stat,
    input  logic [hasi_pkg::KEY_W-1:0]        ip,
    input  logic [hasi_pkg::CNT_W-1:0]        max_entries,
    output logic                              done,
    output logic [hasi_pkg::STATUS_W-1:0]     status,
    output logic [hasi_pkg::CNT_W-1:0]        entries
);

    logic [hasi_pkg::KEY_W-1:0]    key_reg;
    logic [31:0]                   m1_reg;
    logic [31:0]                   m2_reg;
    logic [31:0]                   mix1;
    logic [31:0]                   mix2;
    logic [31:0]                   hval;
    logic [hasi_pkg::SLOT_W-1:0]   slot_reg;
    logic [hasi_pkg::SLOT_W-1:0]   rd_addr;
    logic [hasi_pkg::SLOT_W-1:0]   clr_cnt_reg;
    logic [hasi_pkg::SLOT_W-1:0]   wr_addr;
    logic [hasi_pkg::RAM_W-1:0]    wr_data;
    logic [hasi_pkg::RAM_W-1:0]    rd_data;
    logic                          rd_en;
    logic                          wr_en;
    logic [hasi_pkg::CNT_W-1:0]    count_reg;
    logic [hasi_pkg::CNT_W-1:0]    count_next;
    logic [hasi_pkg::CMP_W-1:0]    limit;
    logic [hasi_pkg::CMP_W-1:0]    room;
    logic [hasi_pkg::CMP_W-1:0]    count_plus;
    logic                          done_reg;
    logic [hasi_pkg::STATUS_W-1:0] status_reg;
    logic [hasi_pkg::CNT_W-1:0]    entries_reg;

    // Mixer stages, one multiply per cycle
    assign mix1 = key_reg ^ (key_reg >> hasi_pkg::HASH_SH_A);
    assign mix2 = m1_reg ^ (m1_reg >> hasi_pkg::HASH_SH_B);
    assign hval = m2_reg ^ (m2_reg >> hasi_pkg::HASH_SH_A);

    always_ff @(posedge clk)
    begin
        if (cmd.load_key)
        begin
            key_reg <= ip;
        end
        if (cmd.hash1)
        begin
            m1_reg <= mix1 * hasi_pkg::HASH_MUL1;
        end
        if (cmd.hash2)
        begin
            m2_reg <= mix2 * hasi_pkg::HASH_MUL2;
        end
        if (rd_en)
        begin
            slot_reg <= rd_addr;
        end
    end

    // Probe address: home slot from the hash, else the next slot with wrap
    assign rd_addr = cmd.rd_home ? hval[hasi_pkg::SLOT_W-1:0]
                                 : slot_reg + hasi_pkg::SLOT_W'(1);
    assign rd_en   = cmd.rd_home | cmd.rd_next;

    // Clearing sweep counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg <= '0;
        end
        else if (cmd.wr_clear)
        begin
            clr_cnt_reg <= clr_cnt_reg + hasi_pkg::SLOT_W'(1);
        end
    end

    // Table write: clear or insert
    assign wr_en   = cmd.wr_clear | cmd.wr_insert;
    assign wr_addr = cmd.wr_clear ? clr_cnt_reg : slot_reg;
    assign wr_data = cmd.wr_clear ? '0 : {1'b1, key_reg};

    hasi_ram #(
        .WIDTH (hasi_pkg::RAM_W),
        .DEPTH (hasi_pkg::CAPACITY)
    ) u_table (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (wr_data),
        .re    (rd_en),
        .raddr (rd_addr),
        .rdata (rd_data)
    );

    // Entry limit: the smaller of the register and CAPACITY - 1
    assign room       = hasi_pkg::CMP_W'(hasi_pkg::CAPACITY - 1);
    assign limit      = (hasi_pkg::CMP_W'(max_entries) < room) ?
                        hasi_pkg::CMP_W'(max_entries) : room;
    assign count_plus = hasi_pkg::CMP_W'(count_reg) + hasi_pkg::CMP_W'(1);
    assign count_next = cmd.wr_insert ? count_reg + hasi_pkg::CNT_W'(1) : count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= cmd.res_strobe;
        end
    end

    // Result word
    always_ff @(posedge clk)
    begin
        if (cmd.res_strobe)
        begin
            status_reg  <= cmd.res_status;
            entries_reg <= count_next;
        end
    end

    assign stat.full     = count_plus > limit;
    assign stat.rd_occ   = rd_data[hasi_pkg::KEY_W];
    assign stat.rd_match = rd_data[hasi_pkg::KEY_W-1:0] == key_reg;
    assign stat.clr_last = &clr_cnt_reg;

    assign done    = done_reg;
    assign status  = status_reg;
    assign entries = entries_reg;

endmodule

// ===== hw/rtl/hashed_address_set_insert.sv =====
`timescale 1ns / 1ps
// Hashed address set, insert only, over a 1024-slot linear probing table.
// Command channel: drive ip with start high; the word is taken at a rising
// edge where start is high and busy is low. Result channel: done is high
// for one cycle with status (inserted, already present, full) and entries,
// the number of keys held after the add. The receiver cannot stall it.
// Timing: an add refused by the entry limit reports in the cycle after it
// is taken and busy never rises. Any other add runs the two multiplier
// stages of the mixer, the address state and one table read per probe;
// done is registered from the strobe of the last probe, and no new word
// is taken until the block is back in idle. The table's single read port
// sets the one probe per cycle.
// Reset: the occupied flags live in the table RAM, so after reset the block
// sweeps all 1024 slots, one per cycle, with busy high until the sweep ends.
// The entry count clears at once and max_entries returns to 716.
// Configuration: APB register max_entries at byte address 0, to be written
// only while idle: the user is bound, the block itself does not enforce it; pready is always high.
module hashed_address_set_insert (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [hasi_pkg::KEY_W-1:0]      ip,
    output logic                            done,
    output logic [hasi_pkg::STATUS_W-1:0]   status,
    output logic [hasi_pkg::CNT_W-1:0]      entries,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [hasi_pkg::PADDR_W-1:0]    paddr,
    input  logic [hasi_pkg::CFG_W-1:0]      pwdata,
    output logic [hasi_pkg::CFG_W-1:0]      prdata,
    output logic                            pready
);

    logic [hasi_pkg::CNT_W-1:0] max_entries_reg;
    logic                       cfg_wr;
    logic                       reg_sel;
    hasi_pkg::ctrl_cmd_t        cmd;
    hasi_pkg::dp_stat_t         stat;

    // Configuration register
    assign pready  = 1'b1;
    assign reg_sel = paddr[2] == hasi_pkg::REG_MAX_ENTRIES;
    assign cfg_wr  = psel & penable & pwrite & pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_entries_reg <= hasi_pkg::MAX_ENTRIES_RST;
        end
        else if (cfg_wr && reg_sel)
        begin
            max_entries_reg <= pwdata[hasi_pkg::CNT_W-1:0];
        end
    end

    assign prdata = reg_sel ? hasi_pkg::CFG_W'(max_entries_reg) : '0;

    hasi_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .cmd   (cmd)
    );

    hasi_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .ip          (ip),
        .max_entries (max_entries_reg),
        .done        (done),
        .status      (status),
        .entries     (entries)
    );

endmodule
